/* src/lpne_pkg.sv */
// Shared types and constants for the length-prefixed NAL extractor.
package lpne_pkg;

  localparam int SIZE_BITS_DEF = 24;
  localparam int SIZE_IN_BITS  = 24;
  localparam int ACCUM_BITS    = 32;
  localparam int LEN_BYTES     = 4;
  localparam int LEN_CNT_BITS  = $clog2(LEN_BYTES);
  localparam int TYPE_BITS     = 5;
  localparam logic [7:0] EPB_BYTE = 8'h03;
  localparam int QDEPTH        = 4;
  localparam int QPTR_BITS     = $clog2(QDEPTH);
  localparam int QCNT_BITS     = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_SKIP = 2'd1,
    PH_EMIT = 2'd2,
    PH_IDLE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       last;
  } item_t;

endpackage

/* src/lpne_front.sv */
// Front end: tracks buffer position, parses length fields, marks bytes of the final unit.
module lpne_front #(
  parameter int SIZE_BITS = lpne_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              byte_valid,
  output logic                              byte_stall,
  input  logic [7:0]                        data_byte,
  input  logic [lpne_pkg::SIZE_IN_BITS-1:0] buffer_size,
  input  logic                              first_of_buffer,
  input  logic                              q_full,
  output logic                              push,
  output lpne_pkg::item_t                   item
);

  localparam int SW = (SIZE_BITS < lpne_pkg::SIZE_IN_BITS) ? SIZE_BITS : lpne_pkg::SIZE_IN_BITS;
  localparam int AW = lpne_pkg::ACCUM_BITS;
  localparam int EW = ((SIZE_BITS > AW) ? SIZE_BITS : AW) + 2;
  localparam logic [SIZE_BITS-1:0] POS_MAX = {SIZE_BITS{1'b1}};
  localparam logic [lpne_pkg::LEN_CNT_BITS-1:0] CNT_LAST =
    lpne_pkg::LEN_CNT_BITS'(lpne_pkg::LEN_BYTES - 1);

  lpne_pkg::phase_t                  phase, phase_next;
  logic [lpne_pkg::LEN_CNT_BITS-1:0] len_cnt, len_cnt_next;
  logic [AW-1:0]                     accum, accum_next;
  logic [SIZE_BITS-1:0]              pos, pos_next;
  logic [SIZE_BITS-1:0]              unit_start, unit_start_next;
  logic [SIZE_BITS-1:0]              size_held, size_held_next;
  logic                              hdr_pend, hdr_pend_next;

  logic                 accept;
  logic [AW-1:0]        acc_shift;
  logic [EW-1:0]        unit_end;
  logic                 emit;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= lpne_pkg::PH_LEN;
      len_cnt    <= '0;
      accum      <= '0;
      pos        <= '0;
      unit_start <= '0;
      size_held  <= '0;
      hdr_pend   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      len_cnt    <= len_cnt_next;
      accum      <= accum_next;
      pos        <= pos_next;
      unit_start <= unit_start_next;
      size_held  <= size_held_next;
      hdr_pend   <= hdr_pend_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    len_cnt_next    = len_cnt;
    accum_next      = accum;
    pos_next        = pos;
    unit_start_next = unit_start;
    size_held_next  = size_held;
    hdr_pend_next   = hdr_pend;
    emit            = 1'b0;
    acc_shift       = '0;
    unit_end        = '0;

    if (first_of_buffer) begin
      size_held_next  = SIZE_BITS'(buffer_size[SW-1:0]);
      pos_next        = '0;
      unit_start_next = '0;
      accum_next      = '0;
      len_cnt_next    = '0;
      hdr_pend_next   = 1'b0;
      phase_next      = lpne_pkg::PH_LEN;
    end

    if (pos_next < size_held_next) begin
      if (phase_next == lpne_pkg::PH_SKIP && pos_next == unit_start_next) begin
        phase_next   = lpne_pkg::PH_LEN;
        accum_next   = '0;
        len_cnt_next = '0;
      end
      case (phase_next)
        lpne_pkg::PH_LEN: begin
          acc_shift  = {accum_next[AW-9:0], data_byte};
          accum_next = acc_shift;
          unit_end   = EW'(unit_start_next) + EW'(acc_shift) + EW'(lpne_pkg::LEN_BYTES);
          if (len_cnt_next == CNT_LAST) begin
            len_cnt_next = '0;
            if (unit_end < EW'(size_held_next)) begin
              unit_start_next = unit_end[SIZE_BITS-1:0];
              phase_next      = (unit_end == EW'(pos_next) + EW'(1)) ?
                                lpne_pkg::PH_LEN : lpne_pkg::PH_SKIP;
              accum_next      = '0;
            end else begin
              phase_next    = lpne_pkg::PH_EMIT;
              hdr_pend_next = 1'b1;
            end
          end else begin
            len_cnt_next = len_cnt_next + 1'b1;
          end
        end
        lpne_pkg::PH_EMIT: begin
          emit          = 1'b1;
          hdr_pend_next = 1'b0;
        end
        default: begin
        end
      endcase
    end else begin
      phase_next = lpne_pkg::PH_IDLE;
    end

    item.data = data_byte;
    item.hdr  = first_of_buffer ? 1'b0 : hdr_pend;
    item.last = ((SIZE_BITS + 1)'(pos_next) + (SIZE_BITS + 1)'(1)) ==
                (SIZE_BITS + 1)'(size_held_next);

    if (pos_next != POS_MAX) begin
      pos_next = pos_next + 1'b1;
    end
  end

  assign push = accept && emit;

endmodule

/* src/lpne_queue.sv */
// Short FIFO of classified bytes between the front and back ends.
module lpne_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lpne_pkg::item_t wr_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output lpne_pkg::item_t rd_item
);

  lpne_pkg::item_t                slots [lpne_pkg::QDEPTH];
  logic [lpne_pkg::QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [lpne_pkg::QCNT_BITS-1:0] count;
  logic                           do_pop;

  assign full      = count == lpne_pkg::QCNT_BITS'(lpne_pkg::QDEPTH);
  assign not_empty = count != '0;
  assign do_pop    = pop && not_empty;
  assign rd_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/lpne_back.sv */
// Back end: emulation-prevention removal, unit type capture and output register.
module lpne_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_not_empty,
  input  lpne_pkg::item_t                    q_item,
  output logic                               pop,
  output logic                               nal_valid,
  input  logic                               nal_stall,
  output logic [7:0]                         out_byte,
  output logic [lpne_pkg::TYPE_BITS-1:0]     unit_type,
  output logic                               is_header,
  output logic                               is_last
);

  logic [1:0]                     zero_run, zero_run_next;
  logic [lpne_pkg::TYPE_BITS-1:0] type_held, type_held_next;
  logic                           drop;
  logic [1:0]                     run_base;

  assign pop       = q_not_empty && (!nal_valid || !nal_stall);
  assign drop      = !q_item.hdr && zero_run == 2'd2 && q_item.data == lpne_pkg::EPB_BYTE;
  assign run_base  = q_item.hdr ? 2'd0 : zero_run;

  always_comb begin
    zero_run_next  = zero_run;
    type_held_next = type_held;
    if (drop) begin
      zero_run_next = 2'd0;
    end else begin
      if (q_item.hdr) begin
        type_held_next = q_item.data[lpne_pkg::TYPE_BITS-1:0];
      end
      if (q_item.data == 8'd0) begin
        zero_run_next = (run_base == 2'd2) ? 2'd2 : run_base + 1'b1;
      end else begin
        zero_run_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nal_valid <= 1'b0;
      zero_run  <= '0;
      type_held <= '0;
    end else if (pop) begin
      nal_valid <= !drop;
      zero_run  <= zero_run_next;
      type_held <= type_held_next;
    end else if (nal_valid && !nal_stall) begin
      nal_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !drop) begin
      out_byte  <= q_item.data;
      unit_type <= type_held_next;
      is_header <= q_item.hdr;
      is_last   <= q_item.last;
    end
  end

endmodule

/* src/length_prefixed_nal_extractor_top.sv */
// Top level of the length-prefixed NAL extractor.
//
//  channel  direction  handshake               payload
//  byte     in         byte_valid/byte_stall   data_byte, buffer_size, first_of_buffer
//  nal      out        nal_valid/nal_stall     out_byte, unit_type, is_header, is_last
//
// One byte beat per cycle in while byte_stall is low; kept bytes leave one per cycle
// while nal_stall is low, passing through the queue write and then the output register.
// The front end stalls only when the four-entry queue is full; the back end drains
// the queue whenever the output register is empty or being taken.
// Synchronous reset clears the parser state, the queue pointers and the output valid.
module length_prefixed_nal_extractor_top #(
  parameter int SIZE_BITS = lpne_pkg::SIZE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               byte_valid,
  output logic                               byte_stall,
  input  logic [7:0]                         data_byte,
  input  logic [lpne_pkg::SIZE_IN_BITS-1:0]  buffer_size,
  input  logic                               first_of_buffer,
  output logic                               nal_valid,
  input  logic                               nal_stall,
  output logic [7:0]                         out_byte,
  output logic [lpne_pkg::TYPE_BITS-1:0]     unit_type,
  output logic                               is_header,
  output logic                               is_last
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_not_empty;
  lpne_pkg::item_t wr_item;
  lpne_pkg::item_t rd_item;

  lpne_front #(
    .SIZE_BITS(SIZE_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .data_byte       (data_byte),
    .buffer_size     (buffer_size),
    .first_of_buffer (first_of_buffer),
    .q_full          (q_full),
    .push            (q_push),
    .item            (wr_item)
  );

  lpne_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_item   (wr_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_item   (rd_item)
  );

  lpne_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_item      (rd_item),
    .pop         (q_pop),
    .nal_valid   (nal_valid),
    .nal_stall   (nal_stall),
    .out_byte    (out_byte),
    .unit_type   (unit_type),
    .is_header   (is_header),
    .is_last     (is_last)
  );

endmodule
